### hw/rtl/sdr_pkg.sv
// Shared types, constants and helper functions for the scale degree to ratio block.
// Used by every module under hw/rtl; depends on nothing else.
package sdr_pkg;

  // Default upper bound on the number of steps in one scale cycle.
  localparam int MaxStepsDefault = 16;
  // Number of step slots held in the configuration registers.
  localparam int NumSlots = 16;
  // Fraction bits of the Q2.30 mantissa.
  localparam int FracBits = 30;
  // Shift that goes with the reciprocal table below.
  localparam int RecipShift = 22;

  // Base-2 log of the twelfth root of two, signed Q8.24.
  localparam logic signed [31:0] Log2BaseReset = 32'sd1398101;
  localparam logic [4:0] StepCountReset = 5'd12;
  // Four slots of 1.0 in Q8.8.
  localparam logic [63:0] StepsUnitReset = 64'h0100_0100_0100_0100;
  // Mantissa value 1.0 in Q2.30.
  localparam logic [31:0] MantOne = 32'h4000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_STEP_COUNT  = 3'd0,
    REG_LOG2_BASE   = 3'd1,
    REG_STEPS_0_3   = 3'd2,
    REG_STEPS_4_7   = 3'd3,
    REG_STEPS_8_11  = 3'd4,
    REG_STEPS_12_15 = 3'd5
  } sdr_reg_e;

  // Item leaving the divider: stage and remainder within the cycle.
  typedef struct packed {
    logic signed [15:0] stage;
    logic [4:0]         rem;
  } sdr_div_t;

  // Item leaving the exponent unit.
  typedef struct packed {
    logic signed [63:0] prod;
    logic signed [31:0] expo;
    logic signed [15:0] stage;
    logic               clip;
  } sdr_exp_t;

  // Reciprocal ceil(2^22 / n) for the step counts 1 to 31; exact floor
  // division of any 17-bit dividend.
  function automatic logic [22:0] sdr_recip(input logic [4:0] n);
    logic [22:0] r;
    case (n)
      5'd1:    r = 23'd4194304;
      5'd2:    r = 23'd2097152;
      5'd3:    r = 23'd1398102;
      5'd4:    r = 23'd1048576;
      5'd5:    r = 23'd838861;
      5'd6:    r = 23'd699051;
      5'd7:    r = 23'd599187;
      5'd8:    r = 23'd524288;
      5'd9:    r = 23'd466034;
      5'd10:   r = 23'd419431;
      5'd11:   r = 23'd381301;
      5'd12:   r = 23'd349526;
      5'd13:   r = 23'd322639;
      5'd14:   r = 23'd299594;
      5'd15:   r = 23'd279621;
      5'd16:   r = 23'd262144;
      5'd17:   r = 23'd246724;
      5'd18:   r = 23'd233017;
      5'd19:   r = 23'd220753;
      5'd20:   r = 23'd209716;
      5'd21:   r = 23'd199729;
      5'd22:   r = 23'd190651;
      5'd23:   r = 23'd182362;
      5'd24:   r = 23'd174763;
      5'd25:   r = 23'd167773;
      5'd26:   r = 23'd161320;
      5'd27:   r = 23'd155345;
      5'd28:   r = 23'd149797;
      5'd29:   r = 23'd144632;
      5'd30:   r = 23'd139811;
      5'd31:   r = 23'd135301;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

  // Root constant for mantissa step i: T0 = 2^31, Ti = isqrt(T(i-1) * 2^30).
  // Evaluated only at elaboration.
  function automatic logic [31:0] sdr_root(input int i);
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] res;
    logic [63:0] bitv;
    t = 64'h8000_0000;
    for (int j = 1; j <= i; j++) begin
      x = t << FracBits;
      res = 64'd0;
      bitv = 64'h4000_0000_0000_0000;
      for (int b = 0; b < 32; b++) begin
        if (x >= res + bitv) begin
          x = x - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      t = res;
    end
    return t[31:0];
  endfunction

endpackage

### hw/rtl/sdr_divide.sv
// Two-stage floor division of the scale index by the step count.
// Depends on sdr_pkg for the reciprocal table and the result type.
module sdr_divide (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [15:0]  scale_index_i,
  input  logic [4:0]          n_i,
  output logic                valid_o,
  output sdr_pkg::sdr_div_t   div_o
);
  import sdr_pkg::*;

  logic               neg;
  logic [16:0]        mag;
  logic [39:0]        prod;
  logic               v1_q;
  logic               neg_q;
  logic [16:0]        quo_q;
  logic signed [15:0] idx_q;
  logic signed [16:0] q17;
  logic signed [21:0] qn;
  logic signed [21:0] rfull;
  logic               v2_q;
  sdr_div_t           div_d;
  sdr_div_t           div_q;

  // Stage one: a negative index divides as -(|idx| + n - 1) so that the
  // quotient rounds toward minus infinity.
  always_comb begin
    neg = scale_index_i[15];
    if (neg) begin
      mag = 17'd0 - {scale_index_i[15], scale_index_i} + {12'd0, n_i} - 17'd1;
    end else begin
      mag = {1'b0, scale_index_i};
    end
    prod = {23'd0, mag} * {17'd0, sdr_recip(n_i)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= neg;
      quo_q <= prod[RecipShift+16:RecipShift];
      idx_q <= scale_index_i;
    end
  end

  // Stage two: apply the sign and recover the remainder.
  always_comb begin
    q17 = neg_q ? $signed(17'd0 - quo_q) : $signed(quo_q);
    qn = $signed({{5{q17[16]}}, q17}) * $signed({17'd0, n_i});
    rfull = $signed({{6{idx_q[15]}}, idx_q}) - qn;
    div_d.stage = q17[15:0];
    div_d.rem = rfull[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign valid_o = v2_q;
  assign div_o = div_q;

endmodule

### hw/rtl/sdr_exponent.sv
// Exponent unit: step sums, stage multiply, saturation and the log2 product.
// Depends on sdr_pkg for the slot count and the item types.
module sdr_exponent (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  sdr_pkg::sdr_div_t       div_i,
  input  logic [4:0]              n_i,
  input  logic signed [31:0]      log2_base_i,
  input  logic [3:0][63:0]        steps_i,
  output logic                    valid_o,
  output sdr_pkg::sdr_exp_t       exp_o
);
  import sdr_pkg::*;

  localparam int NumGroups = NumSlots / 4;

  logic signed [17:0] part_all_d [NumGroups];
  logic signed [17:0] part_pre_d [NumGroups];
  logic signed [17:0] part_all_q [NumGroups];
  logic signed [17:0] part_pre_q [NumGroups];
  logic signed [15:0] stage1_q;
  logic               v1_q;

  logic signed [20:0] sum_d;
  logic signed [20:0] pre_d;
  logic signed [20:0] sum_q;
  logic signed [20:0] pre2_q;
  logic signed [15:0] stage2_q;
  logic               v2_q;

  logic signed [36:0] mul_q;
  logic signed [20:0] pre3_q;
  logic signed [15:0] stage3_q;
  logic               v3_q;

  logic signed [37:0] efull;
  logic signed [31:0] expo_d;
  logic               clip_d;
  logic signed [31:0] expo4_q;
  logic signed [15:0] stage4_q;
  logic               clip4_q;
  logic               v4_q;

  sdr_exp_t           exp_q;
  logic               v5_q;

  // Stage one: masked partial sums over groups of four slots.
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      part_all_d[g] = 18'sd0;
      part_pre_d[g] = 18'sd0;
      for (int j = 0; j < 4; j++) begin
        if (5'(4 * g + j) < n_i) begin
          part_all_d[g] = part_all_d[g]
            + $signed({{2{steps_i[g][16*j+15]}}, steps_i[g][16*j +: 16]});
        end
        if (5'(4 * g + j) < div_i.rem) begin
          part_pre_d[g] = part_pre_d[g]
            + $signed({{2{steps_i[g][16*j+15]}}, steps_i[g][16*j +: 16]});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      part_all_q <= part_all_d;
      part_pre_q <= part_pre_d;
      stage1_q <= div_i.stage;
    end
  end

  // Stage two: add the group sums.
  always_comb begin
    sum_d = 21'sd0;
    pre_d = 21'sd0;
    for (int g = 0; g < NumGroups; g++) begin
      sum_d = sum_d + $signed({{3{part_all_q[g][17]}}, part_all_q[g]});
      pre_d = pre_d + $signed({{3{part_pre_q[g][17]}}, part_pre_q[g]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      pre2_q <= pre_d;
      stage2_q <= stage1_q;
    end
  end

  // Stage three: whole cycles times the cycle width.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mul_q <= 37'(stage2_q) * 37'(sum_q);
      pre3_q <= pre2_q;
      stage3_q <= stage2_q;
    end
  end

  // Stage four: add the partial cycle and clip to 32 bits.
  always_comb begin
    efull = 38'(mul_q) + 38'(pre3_q);
    if (efull[37:31] != {7{efull[37]}}) begin
      clip_d = 1'b1;
      expo_d = efull[37] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      clip_d = 1'b0;
      expo_d = efull[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      expo4_q <= expo_d;
      clip4_q <= clip_d;
      stage4_q <= stage3_q;
    end
  end

  // Stage five: exponent times log2 of the base, Q32.32.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp_q.prod <= 64'(expo4_q) * 64'(log2_base_i);
      exp_q.expo <= expo4_q;
      exp_q.stage <= stage4_q;
      exp_q.clip <= clip4_q;
    end
  end

  assign valid_o = v5_q;
  assign exp_o = exp_q;

endmodule

### hw/rtl/sdr_pow2.sv
// Power-of-two unit: one root multiply per fraction bit, then scaling to Q16.16.
// Depends on sdr_pkg for the root constants and the item type.
module sdr_pow2 (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sdr_pkg::sdr_exp_t   exp_i,
  output logic                valid_o,
  output logic [31:0]         ratio_o,
  output logic signed [31:0]  exponent_o,
  output logic signed [15:0]  stage_o,
  output logic                saturated_o
);
  import sdr_pkg::*;

  logic [31:0] m_q [1:FracBits];
  sdr_exp_t    x_q [1:FracBits];
  logic        v_q [1:FracBits];

  // One stage per fraction bit, from the most significant down.
  for (genvar i = 1; i <= FracBits; i++) begin : g_step
    localparam logic [31:0] Root = sdr_root(i);
    logic [31:0] m_prev;
    sdr_exp_t    x_prev;
    logic        v_prev;
    logic [63:0] prod;

    if (i == 1) begin : g_first
      assign m_prev = MantOne;
      assign x_prev = exp_i;
      assign v_prev = valid_i;
    end else begin : g_next
      assign m_prev = m_q[i-1];
      assign x_prev = x_q[i-1];
      assign v_prev = v_q[i-1];
    end

    assign prod = {32'd0, m_prev} * {32'd0, Root};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i] <= x_prev;
        m_q[i] <= x_prev.prod[32-i] ? prod[FracBits+31:FracBits] : m_prev;
      end
    end
  end

  logic signed [31:0] k;
  logic [4:0]         shamt;
  logic [32:0]        rnd;
  logic [31:0]        ratio_d;
  logic               kbig;
  logic [31:0]        m_last;

  // Final stage: scale the mantissa by the integer part, with rounding, saturation and flush to zero.
  always_comb begin
    m_last = m_q[FracBits];
    k = x_q[FracBits].prod[63:32];
    kbig = (k >= 32'sd16);
    shamt = 5'(32'sd14 - k);
    rnd = {1'b0, m_last} + (33'd1 << (shamt - 5'd1));
    if (kbig) begin
      ratio_d = 32'hFFFF_FFFF;
    end else if (k >= 32'sd14) begin
      ratio_d = k[0] ? {m_last[30:0], 1'b0} : m_last;
    end else if (k < -32'sd17) begin
      ratio_d = 32'd0;
    end else begin
      ratio_d = 32'(rnd >> shamt);
    end
  end

  logic               vo_q;
  logic [31:0]        ratio_q;
  logic signed [31:0] expo_q;
  logic signed [15:0] stage_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= v_q[FracBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ratio_q <= ratio_d;
      expo_q <= x_q[FracBits].expo;
      stage_q <= x_q[FracBits].stage;
      sat_q <= x_q[FracBits].clip | kbig;
    end
  end

  assign valid_o = vo_q;
  assign ratio_o = ratio_q;
  assign exponent_o = expo_q;
  assign stage_o = stage_q;
  assign saturated_o = sat_q;

endmodule

### hw/rtl/scale_degree_to_ratio.sv
// Top level: configuration registers and the divide, exponent and power-of-two pipeline.
// Depends on sdr_pkg, sdr_divide, sdr_exponent and sdr_pow2.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//   in       in         in_valid_i/in_ready_o   scale_index_i
//   out      out        out_valid_o/out_ready_i ratio_o, exponent_o, stage_o, saturated_o
//
// One item enters per cycle while the output is not stalled; each item passes 38 register
// stages (two divider stages, five exponent stages, 30 root-multiply stages and one output
// stage) between acceptance and the output.
// Reset clears all valid bits and loads the default scale. A stalled output
// freezes the whole pipeline; the configuration port is always ready.
module scale_degree_to_ratio #(
  parameter int MAX_STEPS = sdr_pkg::MaxStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] scale_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        ratio_o,
  output logic signed [31:0] exponent_o,
  output logic signed [15:0] stage_o,
  output logic               saturated_o
);
  import sdr_pkg::*;

  // The count register cannot exceed 31.
  localparam int CountCap = (MAX_STEPS < 31) ? MAX_STEPS : 31;

  logic [4:0]         step_count_q;
  logic signed [31:0] log2_base_q;
  logic [3:0][63:0]   steps_q;
  logic [4:0]         n_eff;
  logic               en;

  logic               div_valid;
  sdr_div_t           div_item;
  logic               exp_valid;
  sdr_exp_t           exp_item;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= StepCountReset;
      log2_base_q <= Log2BaseReset;
      steps_q[0] <= StepsUnitReset;
      steps_q[1] <= StepsUnitReset;
      steps_q[2] <= StepsUnitReset;
      steps_q[3] <= 64'd0;
    end else if (cfg_valid_i) begin
      case (sdr_reg_e'(cfg_index_i))
        REG_STEP_COUNT:  step_count_q <= cfg_data_i[4:0];
        REG_LOG2_BASE:   log2_base_q <= cfg_data_i[31:0];
        REG_STEPS_0_3:   steps_q[0] <= cfg_data_i;
        REG_STEPS_4_7:   steps_q[1] <= cfg_data_i;
        REG_STEPS_8_11:  steps_q[2] <= cfg_data_i;
        REG_STEPS_12_15: steps_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Effective step count: zero reads as one, large values clamp.
  always_comb begin
    if (step_count_q == 5'd0) begin
      n_eff = 5'd1;
    end else if (step_count_q > 5'(CountCap)) begin
      n_eff = 5'(CountCap);
    end else begin
      n_eff = step_count_q;
    end
  end

  // Whole pipeline advances unless a finished item waits at the output.
  assign en = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  sdr_divide u_divide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (in_valid_i),
    .scale_index_i (scale_index_i),
    .n_i           (n_eff),
    .valid_o       (div_valid),
    .div_o         (div_item)
  );

  sdr_exponent u_exponent (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (div_valid),
    .div_i       (div_item),
    .n_i         (n_eff),
    .log2_base_i (log2_base_q),
    .steps_i     (steps_q),
    .valid_o     (exp_valid),
    .exp_o       (exp_item)
  );

  sdr_pow2 u_pow2 (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (exp_valid),
    .exp_i       (exp_item),
    .valid_o     (out_valid_o),
    .ratio_o     (ratio_o),
    .exponent_o  (exponent_o),
    .stage_o     (stage_o),
    .saturated_o (saturated_o)
  );

endmodule
